/* src/ipws_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ipws_pkg;

    // Default sizes of the speed samples and of the accumulator.
    localparam int SPEED_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF   = 48;

    // Fixed field widths.
    localparam int GAIN_W     = 14;
    localparam int OLIM_W     = 24;
    localparam int MLIM_W     = 14;
    localparam int BASE_W     = 15;
    localparam int CMD_W      = 15;
    localparam int ADJ_W      = 16;
    localparam int FRAC_BITS  = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // Largest magnitudes that the result values can reach.
    localparam int ADJ_MAX = 1 << (OLIM_W - FRAC_BITS);
    localparam int CMD_MAX = (1 << MLIM_W) - 1;

    // Register values after reset.
    localparam logic [OLIM_W-1:0] OLIM_RST   = OLIM_W'(7372800);
    localparam logic [MLIM_W-1:0] MLIM_RST   = MLIM_W'(3600);
    localparam logic              ENABLE_RST = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KP_GAIN      = 3'd0,
        REG_KI_GAIN      = 3'd1,
        REG_KD_GAIN      = 3'd2,
        REG_OUTPUT_LIMIT = 3'd3,
        REG_MOTOR_LIMIT  = 3'd4,
        REG_ENABLE       = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [OLIM_W-1:0] olim;
        logic [MLIM_W-1:0] mlim;
        logic              enable;
    } t_cfg;

endpackage

`default_nettype wire

/* src/ipws_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

// Speed sample channel.
interface ipws_in_if
    import ipws_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SPEED_WIDTH-1:0] target_speed;
    logic signed [SPEED_WIDTH-1:0] measured_speed;
    logic signed [BASE_W-1:0]      base_command;

    modport source (output valid, target_speed, measured_speed, base_command, input ready);
    modport sink   (input valid, target_speed, measured_speed, base_command, output ready);
endinterface

// Motor command channel.
interface ipws_out_if
    import ipws_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] motor_command;
    logic signed [ADJ_W-1:0] adjust;

    modport source (output valid, motor_command, adjust, input ready);
    modport sink   (input valid, motor_command, adjust, output ready);
endinterface

// Register write channel.
interface ipws_cfg_if
    import ipws_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

/* src/ipws_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module ipws_cfg_regs
    import ipws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ipws_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg,
    output logic       o_hist_clr
);

    t_cfg     r_cfg;
    t_cfg_reg w_reg;

    assign w_reg       = t_cfg_reg'(i_cfg.addr);
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Any gain write restarts the loop from a clean history.
    assign o_hist_clr = i_cfg.valid &&
                        (w_reg inside {REG_KP_GAIN, REG_KI_GAIN, REG_KD_GAIN});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp     <= '0;
            r_cfg.ki     <= '0;
            r_cfg.kd     <= '0;
            r_cfg.olim   <= OLIM_RST;
            r_cfg.mlim   <= MLIM_RST;
            r_cfg.enable <= ENABLE_RST;
        end else if (i_cfg.valid) begin
            case (w_reg)
                REG_KP_GAIN:      r_cfg.kp     <= i_cfg.data[GAIN_W-1:0];
                REG_KI_GAIN:      r_cfg.ki     <= i_cfg.data[GAIN_W-1:0];
                REG_KD_GAIN:      r_cfg.kd     <= i_cfg.data[GAIN_W-1:0];
                REG_OUTPUT_LIMIT: r_cfg.olim   <= i_cfg.data[OLIM_W-1:0];
                REG_MOTOR_LIMIT:  r_cfg.mlim   <= i_cfg.data[MLIM_W-1:0];
                REG_ENABLE:       r_cfg.enable <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/ipws_history.sv */
`timescale 1ns / 1ps
`default_nettype none

module ipws_history
    import ipws_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_enable,
    input  logic                          i_clr,
    input  logic signed [SPEED_WIDTH-1:0] i_target,
    input  logic signed [SPEED_WIDTH-1:0] i_measured,
    output logic signed [SPEED_WIDTH:0]   o_err,
    output logic signed [SPEED_WIDTH+1:0] o_d1,
    output logic signed [SPEED_WIDTH+2:0] o_d2
);

    logic signed [SPEED_WIDTH:0] r_e1;
    logic signed [SPEED_WIDTH:0] r_e2;

    assign o_err = (SPEED_WIDTH+1)'(i_measured) - (SPEED_WIDTH+1)'(i_target);

    // First and second differences of the error; the second difference
    // stays below four times the sample range, so three extra bits hold it.
    assign o_d1 = (SPEED_WIDTH+2)'(o_err) - (SPEED_WIDTH+2)'(r_e1);
    assign o_d2 = (SPEED_WIDTH+3)'(o_err) - ((SPEED_WIDTH+3)'(r_e1) <<< 1)
                + (SPEED_WIDTH+3)'(r_e2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_e1 <= '0;
            r_e2 <= '0;
        end else if (i_load) begin
            if (i_enable) begin
                r_e2 <= r_e1;
                r_e1 <= o_err;
            end else begin
                r_e1 <= '0;
                r_e2 <= '0;
            end
        end
    end

endmodule

`default_nettype wire

/* src/ipws_accum.sv */
`timescale 1ns / 1ps
`default_nettype none

module ipws_accum
    import ipws_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
    parameter int ACC_WIDTH   = ACC_WIDTH_DEF,
    parameter int PW          = SPEED_WIDTH + GAIN_W + 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_enable,
    input  logic                        i_clr,
    input  logic signed [PW-1:0]        i_p_kp,
    input  logic signed [PW-1:0]        i_p_ki,
    input  logic signed [PW-1:0]        i_p_kd,
    output logic signed [ACC_WIDTH-1:0] o_acc
);

    localparam int IW   = PW + 2;
    localparam int SUMW = ((ACC_WIDTH > IW) ? ACC_WIDTH : IW) + 1;

    localparam logic signed [SUMW-1:0] ACC_MAX =
        {{(SUMW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SUMW-1:0] ACC_MIN = ~ACC_MAX;

    logic signed [ACC_WIDTH-1:0] r_acc;
    logic signed [ACC_WIDTH-1:0] n_acc;
    logic signed [IW-1:0]        w_inc;
    logic signed [SUMW-1:0]      w_sum;

    assign w_inc = IW'(i_p_kp) + IW'(i_p_ki) + IW'(i_p_kd);
    assign w_sum = SUMW'(r_acc) + SUMW'(w_inc);

    // The exact sum is wide enough never to wrap, so saturation is a
    // plain compare against the accumulator's signed limits.
    always_comb begin
        if (w_sum > ACC_MAX) begin
            n_acc = {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else if (w_sum < ACC_MIN) begin
            n_acc = {1'b1, {(ACC_WIDTH-1){1'b0}}};
        end else begin
            n_acc = w_sum[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_acc <= '0;
        end else if (i_load) begin
            r_acc <= i_enable ? n_acc : '0;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

/* src/ipws_output.sv */
`timescale 1ns / 1ps
`default_nettype none

module ipws_output
    import ipws_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic signed [ACC_WIDTH-1:0] i_acc,
    input  logic signed [BASE_W-1:0]    i_base,
    input  t_cfg                        i_cfg,
    output logic signed [CMD_W-1:0]     o_cmd,
    output logic signed [ADJ_W-1:0]     o_adj
);

    logic signed [ACC_WIDTH-1:0]        w_lim;
    logic signed [ACC_WIDTH-1:0]        w_nlim;
    logic signed [OLIM_W:0]             w_u;
    logic signed [OLIM_W-FRAC_BITS:0]   w_q;
    logic signed [ADJ_W:0]              w_sum;
    logic signed [ADJ_W:0]              w_mlim;
    logic signed [ADJ_W:0]              w_cmd;

    assign w_lim  = $signed({{(ACC_WIDTH-OLIM_W){1'b0}}, i_cfg.olim});
    assign w_nlim = -w_lim;

    always_comb begin
        if (i_acc > w_lim) begin
            w_u = w_lim[OLIM_W:0];
        end else if (i_acc < w_nlim) begin
            w_u = w_nlim[OLIM_W:0];
        end else begin
            w_u = i_acc[OLIM_W:0];
        end
    end

    // Dropping the fraction bits of a two's complement value rounds
    // toward minus infinity.
    assign w_q   = w_u[OLIM_W:FRAC_BITS];
    assign o_adj = i_cfg.enable ? -(ADJ_W'(w_q)) : '0;

    assign w_sum  = (ADJ_W+1)'(i_base) + (ADJ_W+1)'(o_adj);
    assign w_mlim = $signed({{(ADJ_W+1-MLIM_W){1'b0}}, i_cfg.mlim});

    always_comb begin
        if (w_sum > w_mlim) begin
            w_cmd = w_mlim;
        end else if (w_sum < -w_mlim) begin
            w_cmd = -w_mlim;
        end else begin
            w_cmd = w_sum;
        end
    end

    assign o_cmd = w_cmd[CMD_W-1:0];

endmodule

`default_nettype wire

/* src/incremental_pid_wheel_speed.sv */
`timescale 1ns / 1ps
`default_nettype none

// Incremental (velocity-form) PID speed loop for one wheel with Q10 gains.
// Each speed word forms the error e = measured_speed - target_speed and adds
// kp*(e - e1) + ki*e + kd*(e - 2*e1 + e2) to a saturating accumulator of
// ACC_WIDTH bits; the accumulator is clamped to +-output_limit, shifted down
// by 10 bits and negated to give adjust, and motor_command is base_command
// plus adjust, clamped to +-motor_limit. Clearing enable forces adjust to
// zero and clears the history; any gain write clears it as well. Write the
// registers only while no word is in flight. The block is a five-register
// pipeline (input, error differences, gain products, accumulator, result)
// and takes one word every clock while the result side is ready. The rate
// is set by the accumulator's saturating add, which closes its feedback
// loop through its own register. Each pipeline stage has its own valid
// flag, so bubbles are squeezed out and new words keep entering, until
// the stages fill, while a finished result waits at the output.
// Instantiate the block once per wheel.
module incremental_pid_wheel_speed
    import ipws_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
    parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipws_in_if.sink     i_sample,
    ipws_out_if.source  o_result,
    ipws_cfg_if.sink    i_cfg
);

    // All three products are carried at the width of the widest one.
    localparam int PW = SPEED_WIDTH + GAIN_W + 4;

    t_cfg w_cfg;
    logic w_hist_clr;

    // Stage handshakes: a stage may load when it is empty or its word moves on.
    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3, w_adv4;
    logic w_mv0, w_mv1, w_mv2, w_mv3;
    logic w_in_acc;

    // Input register.
    logic                          r_s0_v;
    logic signed [SPEED_WIDTH-1:0] r_s0_target;
    logic signed [SPEED_WIDTH-1:0] r_s0_measured;
    logic signed [BASE_W-1:0]      r_s0_base;

    // Error and its differences.
    logic signed [SPEED_WIDTH:0]   w_err;
    logic signed [SPEED_WIDTH+1:0] w_d1;
    logic signed [SPEED_WIDTH+2:0] w_d2;
    logic                          r_s1_v;
    logic signed [SPEED_WIDTH:0]   r_s1_e;
    logic signed [SPEED_WIDTH+1:0] r_s1_d1;
    logic signed [SPEED_WIDTH+2:0] r_s1_d2;
    logic signed [BASE_W-1:0]      r_s1_base;

    // Gain products.
    logic signed [GAIN_W:0]                 w_g_kp, w_g_ki, w_g_kd;
    logic signed [GAIN_W+SPEED_WIDTH+2:0]   w_p_kp;
    logic signed [GAIN_W+SPEED_WIDTH+1:0]   w_p_ki;
    logic signed [GAIN_W+SPEED_WIDTH+3:0]   w_p_kd;
    logic                                   r_s2_v;
    logic signed [PW-1:0]                   r_s2_p_kp, r_s2_p_ki, r_s2_p_kd;
    logic signed [BASE_W-1:0]               r_s2_base;

    // Accumulator stage; the accumulator itself lives in ipws_accum.
    logic                        r_s3_v;
    logic signed [BASE_W-1:0]    r_s3_base;
    logic signed [ACC_WIDTH-1:0] w_acc;

    // Result register.
    logic signed [CMD_W-1:0] w_cmd;
    logic signed [ADJ_W-1:0] w_adj;
    logic                    r_out_v;
    logic signed [CMD_W-1:0] r_out_cmd;
    logic signed [ADJ_W-1:0] r_out_adj;

    ipws_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .o_cfg      (w_cfg),
        .o_hist_clr (w_hist_clr)
    );

    // Ready ripples back from the result register through each stage.
    assign w_adv4 = !r_out_v || o_result.ready;
    assign w_rdy3 = !r_s3_v || w_adv4;
    assign w_rdy2 = !r_s2_v || w_rdy3;
    assign w_rdy1 = !r_s1_v || w_rdy2;
    assign w_rdy0 = !r_s0_v || w_rdy1;

    assign w_mv0 = r_s0_v && w_rdy1;
    assign w_mv1 = r_s1_v && w_rdy2;
    assign w_mv2 = r_s2_v && w_rdy3;
    assign w_mv3 = r_s3_v && w_adv4;

    assign i_sample.ready = w_rdy0;
    assign w_in_acc       = i_sample.valid && w_rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_s0_v <= i_sample.valid;
            end
            if (w_rdy1) begin
                r_s1_v <= r_s0_v;
            end
            if (w_rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (w_rdy3) begin
                r_s3_v <= r_s2_v;
            end
            if (w_adv4) begin
                r_out_v <= r_s3_v;
            end
        end
    end

    // Stage 0: capture the word.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s0_target   <= i_sample.target_speed;
            r_s0_measured <= i_sample.measured_speed;
            r_s0_base     <= i_sample.base_command;
        end
    end

    // Stage 1: the error history shifts as the word leaves the input register.
    ipws_history #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_history (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_mv0),
        .i_enable   (w_cfg.enable),
        .i_clr      (w_hist_clr),
        .i_target   (r_s0_target),
        .i_measured (r_s0_measured),
        .o_err      (w_err),
        .o_d1       (w_d1),
        .o_d2       (w_d2)
    );

    always_ff @(posedge i_clk) begin
        if (w_mv0) begin
            r_s1_e    <= w_err;
            r_s1_d1   <= w_d1;
            r_s1_d2   <= w_d2;
            r_s1_base <= r_s0_base;
        end
    end

    // Stage 2: three independent gain multiplies, each straight into a register.
    assign w_g_kp = $signed({1'b0, w_cfg.kp});
    assign w_g_ki = $signed({1'b0, w_cfg.ki});
    assign w_g_kd = $signed({1'b0, w_cfg.kd});

    assign w_p_kp = (GAIN_W+SPEED_WIDTH+3)'(w_g_kp) * (GAIN_W+SPEED_WIDTH+3)'(r_s1_d1);
    assign w_p_ki = (GAIN_W+SPEED_WIDTH+2)'(w_g_ki) * (GAIN_W+SPEED_WIDTH+2)'(r_s1_e);
    assign w_p_kd = (GAIN_W+SPEED_WIDTH+4)'(w_g_kd) * (GAIN_W+SPEED_WIDTH+4)'(r_s1_d2);

    always_ff @(posedge i_clk) begin
        if (w_mv1) begin
            r_s2_p_kp <= PW'(w_p_kp);
            r_s2_p_ki <= PW'(w_p_ki);
            r_s2_p_kd <= PW'(w_p_kd);
            r_s2_base <= r_s1_base;
        end
    end

    // Stage 3: the accumulator takes the increment as the products move on.
    ipws_accum #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .ACC_WIDTH   (ACC_WIDTH),
        .PW          (PW)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_mv2),
        .i_enable (w_cfg.enable),
        .i_clr    (w_hist_clr),
        .i_p_kp   (r_s2_p_kp),
        .i_p_ki   (r_s2_p_ki),
        .i_p_kd   (r_s2_p_kd),
        .o_acc    (w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (w_mv2) begin
            r_s3_base <= r_s2_base;
        end
    end

    // Stage 4: the next word cannot reach the accumulator until this one
    // has left stage 3, so the accumulator still holds this word's value.
    ipws_output #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_output (
        .i_acc  (w_acc),
        .i_base (r_s3_base),
        .i_cfg  (w_cfg),
        .o_cmd  (w_cmd),
        .o_adj  (w_adj)
    );

    always_ff @(posedge i_clk) begin
        if (w_mv3) begin
            r_out_cmd <= w_cmd;
            r_out_adj <= w_adj;
        end
    end

    assign o_result.valid         = r_out_v;
    assign o_result.motor_command = r_out_cmd;
    assign o_result.adjust        = r_out_adj;

`ifndef SYNTHESIS
    // A gain write leaves the accumulator cleared.
    a_gain_write_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hist_clr |=> (w_acc == '0))
        else $error("accumulator not cleared after gain write");

    // A word held in the input register is never dropped while stalled.
    a_s0_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_v && !w_rdy1) |=> r_s0_v)
        else $error("stalled input word lost");

    // The adjustment never exceeds the shifted output range.
    a_adj_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((o_result.adjust <= ADJ_W'(ADJ_MAX)) &&
                            (o_result.adjust >= -(ADJ_W'(ADJ_MAX)))))
        else $error("adjust out of range");

    // The clamped command never reaches the most negative code.
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.motor_command >= -(CMD_W'(CMD_MAX))))
        else $error("motor command out of range");
`endif

endmodule

`default_nettype wire

/* sim/tb_incremental_pid_wheel_speed.sv */
`timescale 1ns / 1ps

// Self-checking bench for the incremental PID wheel speed loop.
module tb_incremental_pid_wheel_speed;
    import ipws_pkg::*;

    localparam int SPW = SPEED_WIDTH_DEF;
    localparam int ACW = ACC_WIDTH_DEF;

    // Random traffic is split into phases, each with its own register setting.
    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 100;

    // With ki at its largest and the error at its largest, the integral term adds
    // about 2^30 per word, so this many words wind the accumulator far past any
    // output limit and pin the adjustment at its clamp.
    localparam int SAT_WORDS = 60;

    // Mismatch printing is capped so a broken build cannot flood the log.
    localparam int REPORT_LIMIT = 30;

    // Drain time after the end; this covers stray words from the pipeline.
    localparam int DRAIN_CYCLES = 16;

    // Slowest legal run is about 0.2 ms; this is ten times that.
    localparam longint TIMEOUT_NS = 2_000_000;

    // Register indexes that the block does not decode; writes to them are dropped.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic signed [SPW-1:0]    SPEED_MAX = {1'b0, {(SPW-1){1'b1}}};
    localparam logic signed [SPW-1:0]    SPEED_MIN = {1'b1, {(SPW-1){1'b0}}};
    localparam logic signed [BASE_W-1:0] BASE_MAX  = {1'b0, {(BASE_W-1){1'b1}}};
    localparam logic signed [BASE_W-1:0] BASE_MIN  = {1'b1, {(BASE_W-1){1'b0}}};
    localparam logic [CFG_DATA_W-1:0]    DATA_ONES = '1;

    // One motor command word as the block should emit it.
    typedef struct {
        logic signed [CMD_W-1:0] motor_command;
        logic signed [ADJ_W-1:0] adjust;
    } wheel_cmd_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ipws_in_if #(.SPEED_WIDTH(SPW)) sample_if ();
    ipws_out_if                     result_if ();
    ipws_cfg_if                     cfg_if ();

    incremental_pid_wheel_speed uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    always #2 i_clk = ~i_clk;

    // Commands predicted for accepted speed words, oldest first.
    wheel_cmd_t pending_cmds[$];
    int         error_count = 0;

    // Idling switches: idle_on lets the sender leave gaps between words and
    // stall_on lets the result side drop ready in bursts.
    bit idle_on  = 1'b0;
    bit stall_on = 1'b0;

    // Shadow of the control loop: register file, accumulator and the two most
    // recent errors, kept at the block's own widths.
    t_cfg                  loop_cfg;
    logic signed [ACW-1:0] acc_q;
    logic signed [SPW:0]   err_last_q;
    logic signed [SPW:0]   err_older_q;

    function automatic void clear_history();
        acc_q       = '0;
        err_last_q  = '0;
        err_older_q = '0;
    endfunction

    function automatic longint clamp_sym(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // Mirrors one register write. Only the low bits of the data that fit the
    // register are kept, and any gain write restarts the loop from zero.
    function automatic void apply_register(input logic [CFG_ADDR_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_KP_GAIN: begin
                loop_cfg.kp = data[GAIN_W-1:0];
                clear_history();
            end
            REG_KI_GAIN: begin
                loop_cfg.ki = data[GAIN_W-1:0];
                clear_history();
            end
            REG_KD_GAIN: begin
                loop_cfg.kd = data[GAIN_W-1:0];
                clear_history();
            end
            REG_OUTPUT_LIMIT: loop_cfg.olim   = data[OLIM_W-1:0];
            REG_MOTOR_LIMIT:  loop_cfg.mlim   = data[MLIM_W-1:0];
            REG_ENABLE:       loop_cfg.enable = data[0];
            default: ;
        endcase
    endfunction

    // Runs one control step on the shadow state and returns the command word.
    // The increment is computed in 64 bits, which holds the widest product sum
    // with room to spare, and then saturates at the accumulator's rails.
    function automatic wheel_cmd_t predict_wheel_command(
        input logic signed [SPW-1:0]    tgt,
        input logic signed [SPW-1:0]    meas,
        input logic signed [BASE_W-1:0] base
    );
        longint     err;
        longint     incr;
        longint     sum;
        longint     rail_hi;
        longint     rail_lo;
        longint     clipped;
        longint     adj;
        wheel_cmd_t word;

        rail_hi = (longint'(1) <<< (ACW - 1)) - 1;
        rail_lo = -rail_hi - 1;
        adj     = 0;
        if (loop_cfg.enable) begin
            err  = longint'(meas) - longint'(tgt);
            incr = longint'(loop_cfg.kp) * (err - err_last_q)
                 + longint'(loop_cfg.ki) * err
                 + longint'(loop_cfg.kd) * (err - 2 * err_last_q + err_older_q);
            sum = acc_q;
            if (incr > 0 && sum > rail_hi - incr)
                sum = rail_hi;
            else if (incr < 0 && sum < rail_lo - incr)
                sum = rail_lo;
            else
                sum = sum + incr;
            acc_q       = ACW'(sum);
            err_older_q = err_last_q;
            err_last_q  = (SPW+1)'(err);

            // Arithmetic shift floors, so a negative clipped value rounds away
            // from zero and the adjustment can reach +16384.
            clipped = clamp_sym(sum, longint'(loop_cfg.olim));
            adj     = -(clipped >>> FRAC_BITS);
        end else begin
            clear_history();
        end
        word.motor_command = CMD_W'(clamp_sym(longint'(base) + adj,
                                              longint'(loop_cfg.mlim)));
        word.adjust        = ADJ_W'(adj);
        return word;
    endfunction

    // Result side: ready is driven at the falling edge, held low in random
    // bursts while stalling is switched on.
    initial begin : result_sink
        int hold;
        hold            = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0 && stall_on && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 10);
            if (hold > 0) begin
                result_if.ready <= 1'b0;
                hold--;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Every accepted command word is compared field by field with the oldest
    // prediction. A word with nothing pending is an error as well.
    always @(posedge i_clk) begin : check_commands
        wheel_cmd_t want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_cmds.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected word, expected none, got cmd %0d adjust %0d",
                             $time, result_if.motor_command, result_if.adjust);
            end else begin
                want = pending_cmds.pop_front();
                if (result_if.motor_command !== want.motor_command) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: motor_command expected %0d, got %0d",
                                 $time, want.motor_command, result_if.motor_command);
                end
                if (result_if.adjust !== want.adjust) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: adjust expected %0d, got %0d",
                                 $time, want.adjust, result_if.adjust);
                end
            end
        end
    end

    // Offers one speed word and waits for the block to take it. The
    // prediction is made at the accepting edge, so it follows accept order.
    // Valid stays high into the next call unless a gap is taken there.
    task automatic send_speed_word(input logic signed [SPW-1:0]    tgt,
                                   input logic signed [SPW-1:0]    meas,
                                   input logic signed [BASE_W-1:0] base);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            sample_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        sample_if.valid          <= 1'b1;
        sample_if.target_speed   <= tgt;
        sample_if.measured_speed <= meas;
        sample_if.base_command   <= base;
        do @(posedge i_clk); while (!sample_if.ready);
        pending_cmds.push_back(predict_wheel_command(tgt, meas, base));
    endtask

    // Stops offering words and waits until every predicted command is back.
    // Since every word yields exactly one command, the block is idle then.
    task automatic wait_for_results();
        @(negedge i_clk);
        sample_if.valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    // Register writes only happen with the pipeline empty.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_register(idx, data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Gains come from the useful range half the time, with the extremes and
    // full-width data (upper bits discarded) mixed in.
    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return DATA_ONES;
            2:       return CFG_DATA_W'($urandom);
            5:       return CFG_DATA_W'($urandom_range(0, 300));
            default: return CFG_DATA_W'($urandom_range(0, 10240));
        endcase
    endfunction

    // Random speed word. Most words look like a running loop, with the
    // measured speed close to the target; the rest span the full field range.
    task automatic send_random_word();
        logic signed [SPW-1:0]    tgt;
        logic signed [SPW-1:0]    meas;
        logic signed [BASE_W-1:0] base;
        int                       t;
        if ($urandom_range(0, 3) == 0) begin
            tgt  = SPW'($urandom);
            meas = SPW'($urandom);
        end else begin
            t    = int'($urandom_range(0, 6000)) - 3000;
            tgt  = SPW'(t);
            meas = SPW'(t + int'($urandom_range(0, 256)) - 128);
        end
        if ($urandom_range(0, 1) == 0)
            base = BASE_W'($urandom);
        else
            base = BASE_W'(int'($urandom_range(0, 8000)) - 4000);
        send_speed_word(tgt, meas, base);
    endtask

    // With gains at zero only the base command passes, clamped by the reset
    // motor limit. A single ki write then exposes the reset output limit.
    task automatic test_reset_values();
        send_speed_word(SPEED_MAX, SPEED_MIN, BASE_MAX);
        send_speed_word(SPEED_MIN, SPEED_MAX, BASE_MIN);
        send_speed_word('0, '0, 15'sd3600);
        send_speed_word('0, 16'sd5, -15'sd3601);
        write_reg(REG_KI_GAIN, DATA_ONES);
        send_speed_word(SPEED_MAX, SPEED_MIN, '0);
        send_speed_word(SPEED_MAX, SPEED_MIN, BASE_MIN);
    endtask

    // Hand-picked corners: masked register data, small errors through all
    // three terms, the largest errors of both signs, the floor of a negative
    // shift, zero limits, ignored indexes, disable and gain-write clearing.
    task automatic test_directed_cases();
        write_reg(REG_KP_GAIN, 24'hFFC400);
        write_reg(REG_KI_GAIN, 24'h000200);
        write_reg(REG_KD_GAIN, 24'h000100);
        write_reg(REG_OUTPUT_LIMIT, DATA_ONES);
        write_reg(REG_MOTOR_LIMIT, DATA_ONES);
        write_reg(REG_ENABLE, DATA_ONES);
        send_speed_word('0, 16'sd100, '0);
        send_speed_word('0, 16'sd50, '0);
        send_speed_word('0, -16'sd30, '0);

        // The clipped accumulator hits -16777215, which shifts to -16384.
        send_speed_word(SPEED_MAX, SPEED_MIN, BASE_MAX);
        send_speed_word(SPEED_MAX, SPEED_MIN, BASE_MIN);
        send_speed_word(SPEED_MIN, SPEED_MAX, BASE_MIN);
        send_speed_word(SPEED_MIN, SPEED_MAX, BASE_MAX);

        write_reg(REG_OUTPUT_LIMIT, '0);
        send_speed_word(SPEED_MAX, SPEED_MIN, 15'sd1234);
        write_reg(REG_MOTOR_LIMIT, '0);
        send_speed_word(SPEED_MIN, SPEED_MAX, BASE_MAX);
        write_reg(REG_MOTOR_LIMIT, 24'h00FFFF);
        write_reg(REG_OUTPUT_LIMIT, 24'h0003FF);
        send_speed_word(SPEED_MAX, -16'sd1, '0);

        write_reg(REG_SPARE_6, DATA_ONES);
        write_reg(REG_SPARE_7, DATA_ONES);
        send_speed_word('0, 16'sd7, -15'sd9);

        // Disable with the upper data bits set: only bit 0 counts.
        write_reg(REG_OUTPUT_LIMIT, DATA_ONES);
        write_reg(REG_ENABLE, 24'hFFFFFE);
        send_speed_word(SPEED_MAX, SPEED_MIN, 15'sd77);
        write_reg(REG_ENABLE, 24'h000001);
        send_speed_word('0, 16'sd300, '0);
        send_speed_word('0, 16'sd300, '0);

        // Rewriting a gain to its own value still clears the history.
        write_reg(REG_KD_GAIN, 24'h000100);
        send_speed_word('0, 16'sd300, '0);
    endtask

    // New setting between phases. Each register is rewritten most of the
    // time; skipping the gains lets the history carry across phases.
    task automatic randomize_settings(input bit all_regs);
        logic [CFG_DATA_W-1:0] data;
        if (all_regs || $urandom_range(0, 3) != 0)
            write_reg(REG_KP_GAIN, pick_gain());
        if (all_regs || $urandom_range(0, 3) != 0)
            write_reg(REG_KI_GAIN, pick_gain());
        if (all_regs || $urandom_range(0, 3) != 0)
            write_reg(REG_KD_GAIN, pick_gain());
        if (all_regs || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
                0:       data = '0;
                1:       data = DATA_ONES;
                2:       data = CFG_DATA_W'(OLIM_RST);
                3:       data = CFG_DATA_W'($urandom_range(0, 1 << 20));
                default: data = CFG_DATA_W'($urandom);
            endcase
            write_reg(REG_OUTPUT_LIMIT, data);
        end
        if (all_regs || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
                0:       data = '0;
                1:       data = DATA_ONES;
                2:       data = CFG_DATA_W'(MLIM_RST);
                3:       data = CFG_DATA_W'($urandom);
                default: data = CFG_DATA_W'($urandom_range(0, CMD_MAX));
            endcase
            write_reg(REG_MOTOR_LIMIT, data);
        end
        if (all_regs || $urandom_range(0, 3) != 0) begin
            data    = CFG_DATA_W'($urandom);
            data[0] = ($urandom_range(0, 4) != 0);
            write_reg(REG_ENABLE, data);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, CFG_DATA_W'($urandom));
    endtask

    // Random traffic in phases, with idling on either side switched per phase
    // so that some phases run at full rate. Halfway through the first phase
    // (and some later ones) the sender holds back until the pipeline is empty.
    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            randomize_settings(p == 0);
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                if (i == WORDS_PER_PHASE / 2 && (p == 0 || $urandom_range(0, 3) == 0))
                    wait_for_results();
                send_random_word();
            end
        end
    endtask

    // Any base command over the full field range.
    function automatic logic signed [BASE_W-1:0] BASE_NEG_OR_POS();
        return BASE_W'($urandom);
    endfunction

    // Winds the accumulator far past the positive output limit, checks a few
    // words of unwinding, then restarts and winds it past the negative limit.
    // This is the closing stretch, so both sides run without idling.
    task automatic test_accumulator_saturation();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        write_reg(REG_KP_GAIN, pick_gain());
        write_reg(REG_KD_GAIN, pick_gain());
        write_reg(REG_KI_GAIN, DATA_ONES);
        write_reg(REG_OUTPUT_LIMIT, DATA_ONES);
        write_reg(REG_MOTOR_LIMIT, DATA_ONES);
        write_reg(REG_ENABLE, DATA_ONES);
        repeat (SAT_WORDS)
            send_speed_word(SPEED_MIN, SPEED_MAX, BASE_NEG_OR_POS());
        repeat (20)
            send_random_word();
        write_reg(REG_KI_GAIN, DATA_ONES);
        repeat (SAT_WORDS)
            send_speed_word(SPEED_MAX, SPEED_MIN, BASE_NEG_OR_POS());
        repeat (20)
            send_random_word();
    endtask

    // Main sequence: every input is known from time zero, reset is held low
    // at the start, then each test runs in turn. After the last word the bench
    // waits for every command and then drains to catch stray words.
    initial begin
        sample_if.valid          = 1'b0;
        sample_if.target_speed   = '0;
        sample_if.measured_speed = '0;
        sample_if.base_command   = '0;
        cfg_if.valid             = 1'b0;
        cfg_if.addr              = '0;
        cfg_if.data              = '0;
        i_rst_n                  = 1'b0;
        loop_cfg = '{kp: '0, ki: '0, kd: '0, olim: OLIM_RST, mlim: MLIM_RST,
                     enable: ENABLE_RST};
        clear_history();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_directed_cases();
        test_random_traffic();
        test_accumulator_saturation();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_incremental_pid_wheel_speed: done, clean");
        end else begin
            $display("tb_incremental_pid_wheel_speed: done, errors");
        end
        $finish;
    end

    // Watchdog for a block that stops handshaking.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_incremental_pid_wheel_speed: done, errors");
        $finish;
    end

endmodule

/* sim.f */
src/ipws_pkg.sv
src/ipws_ifs.sv
src/ipws_cfg_regs.sv
src/ipws_history.sv
src/ipws_accum.sv
src/ipws_output.sv
src/incremental_pid_wheel_speed.sv
sim/tb_incremental_pid_wheel_speed.sv
